@@ rtl/core/rpi_pkg.sv @@
// Shared types, constants and saturation helper for the ray/plane intersection pipeline.
package rpi_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int UNIT_SHIFT = 30;
    localparam int THR_W      = 31;
    localparam int UV_W       = 36;
    localparam int DIV_LAT    = 64;
    localparam int SQRT_LAT   = 32;
    localparam int UNIT_LAT   = SQRT_LAT + DIV_LAT + 6;

    localparam logic signed [63:0] UNIT_ONE = 64'sd1 <<< UNIT_SHIFT;

    typedef logic signed [31:0] s32_t;
    typedef logic [2:0][31:0] vec32_t;
    typedef logic [2:0][UV_W-1:0] uvec_t;

    typedef struct packed {
        logic       vld;
        logic       hit;
        logic       ov;
        logic [1:0] sel_a;
        logic [1:0] sel_b;
        logic [2:0] qneg;
        vec32_t     org;
        vec32_t     dir;
        vec32_t     nrm;
        vec32_t     pt;
        vec32_t     b1;
        uvec_t      tv;
    } ctx_t;

    typedef struct packed {
        logic ov;
        s32_t val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [71:0] x);
        sat_t r;
        r.ov  = 1'b0;
        r.val = x[31:0];
        if (x > 72'sd2147483647) begin
            r.ov  = 1'b1;
            r.val = 32'sh7fffffff;
        end else if (x < -72'sd2147483648) begin
            r.ov  = 1'b1;
            r.val = 32'sh80000000;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/rpi_div.sv @@
// Pipelined unsigned restoring divider, 64-bit dividend by 32-bit divisor, one bit per stage.
module rpi_div (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic [63:0] quo
);

    logic [31:0] rem_reg [rpi_pkg::DIV_LAT];
    logic [63:0] num_reg [rpi_pkg::DIV_LAT];
    logic [63:0] quo_reg [rpi_pkg::DIV_LAT];
    logic [31:0] den_reg [rpi_pkg::DIV_LAT];

    for (genvar j = 0; j < rpi_pkg::DIV_LAT; j++) begin : g_stage
        logic [31:0] rem_in;
        logic [63:0] num_in;
        logic [63:0] quo_in;
        logic [31:0] den_in;
        logic [32:0] trial;
        logic        qbit;
        logic [31:0] rem_next;

        if (j == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = num;
            assign quo_in = '0;
            assign den_in = den;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign num_in = num_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign den_in = den_reg[j-1];
        end

        always_comb
        begin
            trial    = {rem_in, num_in[63]};
            qbit     = (trial >= {1'b0, den_in});
            rem_next = qbit ? 32'(trial - {1'b0, den_in}) : trial[31:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                num_reg[j] <= {num_in[62:0], 1'b0};
                quo_reg[j] <= {quo_in[62:0], qbit};
                den_reg[j] <= den_in;
            end
        end
    end

    assign quo = quo_reg[rpi_pkg::DIV_LAT-1];

endmodule

@@ rtl/core/rpi_sqrt.sv @@
// Pipelined 64-bit integer square root, one result bit per stage.
module rpi_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] rad,
    output logic [31:0] root
);

    logic [63:0] x_reg [rpi_pkg::SQRT_LAT];
    logic [63:0] r_reg [rpi_pkg::SQRT_LAT];

    for (genvar j = 0; j < rpi_pkg::SQRT_LAT; j++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] x_in;
        logic [63:0] r_in;
        logic [63:0] x_next;
        logic [63:0] r_next;

        if (j == 0) begin : g_first
            assign x_in = rad;
            assign r_in = '0;
        end else begin : g_rest
            assign x_in = x_reg[j-1];
            assign r_in = r_reg[j-1];
        end

        always_comb
        begin
            if (x_in >= r_in + BIT)
            begin
                x_next = x_in - (r_in + BIT);
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[j] <= x_next;
                r_reg[j] <= r_next;
            end
        end
    end

    assign root = r_reg[rpi_pkg::SQRT_LAT-1][31:0];

endmodule

@@ rtl/core/rpi_unit.sv @@
// Vector normalization to Q2.30: range scaling, length by square root, per-lane division.
module rpi_unit (
    input  logic                clk,
    input  logic                en,
    input  rpi_pkg::uvec_t      vec_in,
    output rpi_pkg::vec32_t     vec_out
);

    typedef struct packed {
        logic [2:0]       neg;
        logic             zero;
        logic [2:0][31:0] m;
    } uctx_t;

    // stage 1: magnitudes and largest magnitude
    logic [2:0][rpi_pkg::UV_W-1:0] m1_reg, m1_next;
    logic [2:0]                    neg1_reg, neg1_next;
    logic [rpi_pkg::UV_W-1:0]      mx1_reg, mx1_next;
    // stage 2: leading one of the largest magnitude
    logic [2:0][rpi_pkg::UV_W-1:0] m2_reg;
    logic [2:0]                    neg2_reg;
    logic [rpi_pkg::UV_W-1:0]      mx2_reg;
    logic [5:0]                    p2_reg, p2_next;
    logic                          zero2_reg;
    // stage 3: scaled magnitudes
    uctx_t                         u3_reg, u3_next;
    logic                          sh_left;
    logic [5:0]                    sh_amt;
    logic [rpi_pkg::UV_W-1:0]      mm;
    // stage 4 and 5: squares and their sum
    uctx_t                         u4_reg;
    logic [63:0]                   sq_reg [3];
    uctx_t                         u5_reg;
    logic [63:0]                   sum_reg;
    // alignment with the square root and divider
    uctx_t                         sq_pipe [rpi_pkg::SQRT_LAT];
    uctx_t                         dv_pipe [rpi_pkg::DIV_LAT];
    logic [31:0]                   len;
    logic [63:0]                   quo [3];
    rpi_pkg::vec32_t               out_reg, out_next;

    always_comb
    begin
        mx1_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg1_next[i] = vec_in[i][rpi_pkg::UV_W-1];
            m1_next[i]   = neg1_next[i] ? (~vec_in[i] + 1'b1) : vec_in[i];
            if (m1_next[i] > mx1_next)
                mx1_next = m1_next[i];
        end
    end

    always_comb
    begin
        p2_next = '0;
        for (int j = 0; j < rpi_pkg::UV_W; j++)
            if (mx1_reg[j])
                p2_next = 6'(j);
    end

    // scale so the largest magnitude lands in [2^30, 2^31]
    always_comb
    begin
        sh_left = 1'b0;
        sh_amt  = '0;
        mm      = '0;
        if (p2_reg < 6'd30)
        begin
            sh_left = 1'b1;
            sh_amt  = 6'd30 - p2_reg;
        end
        else if (p2_reg > 6'd30)
        begin
            sh_amt = p2_reg - 6'd31;
            if ((mx2_reg >> sh_amt) != 36'h0_8000_0000)
                sh_amt = sh_amt + 6'd1;
        end
        u3_next.neg  = neg2_reg;
        u3_next.zero = zero2_reg;
        for (int i = 0; i < 3; i++)
        begin
            mm = sh_left ? (m2_reg[i] << sh_amt) : (m2_reg[i] >> sh_amt);
            u3_next.m[i] = mm[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg    <= m1_next;
            neg1_reg  <= neg1_next;
            mx1_reg   <= mx1_next;
            m2_reg    <= m1_reg;
            neg2_reg  <= neg1_reg;
            mx2_reg   <= mx1_reg;
            p2_reg    <= p2_next;
            zero2_reg <= (mx1_reg == '0);
            u3_reg    <= u3_next;
            u4_reg    <= u3_reg;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= 64'(u3_reg.m[i]) * 64'(u3_reg.m[i]);
            u5_reg    <= u4_reg;
            sum_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sq_pipe[0] <= u5_reg;
            for (int i = 1; i < rpi_pkg::SQRT_LAT; i++)
                sq_pipe[i] <= sq_pipe[i-1];
            dv_pipe[0] <= sq_pipe[rpi_pkg::SQRT_LAT-1];
            for (int i = 1; i < rpi_pkg::DIV_LAT; i++)
                dv_pipe[i] <= dv_pipe[i-1];
            out_reg   <= out_next;
        end
    end

    rpi_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (sum_reg),
        .root (len)
    );

    for (genvar i = 0; i < 3; i++) begin : g_lane
        rpi_div u_div (
            .clk (clk),
            .en  (en),
            .num ({2'b00, sq_pipe[rpi_pkg::SQRT_LAT-1].m[i], 30'd0}),
            .den (len),
            .quo (quo[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_pipe[rpi_pkg::DIV_LAT-1].zero)
                out_next[i] = '0;
            else if (dv_pipe[rpi_pkg::DIV_LAT-1].neg[i])
                out_next[i] = ~quo[i][31:0] + 1'b1;
            else
                out_next[i] = quo[i][31:0];
        end
    end

    assign vec_out = out_reg;

endmodule

@@ rtl/core/ray_plane_intersect_uv.sv @@
// Top level of the ray/plane intersection pipeline with in-plane coordinates.
//
// Accepts one ray/plane pair per clock and returns hit, coord_u, coord_v and
// overflow; the depth comes from the 64-stage hit-point dividers and the three
// 102-stage normalization units (square root plus divider each) in series. All
// stages advance together: when a result sits at the output and out_stall is
// high, the whole pipeline holds and in_stall is raised. parallel_threshold
// resets to 1 and must be written through cfg_valid/cfg_data (cfg_ready is
// always high) while the pipeline is empty; the block does not enforce this.
module ray_plane_intersect_uv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [31:0]            origin_x,
    input  logic signed [31:0]            origin_y,
    input  logic signed [31:0]            origin_z,
    input  logic signed [31:0]            direction_x,
    input  logic signed [31:0]            direction_y,
    input  logic signed [31:0]            direction_z,
    input  logic signed [31:0]            plane_point_x,
    input  logic signed [31:0]            plane_point_y,
    input  logic signed [31:0]            plane_point_z,
    input  logic signed [31:0]            normal_x,
    input  logic signed [31:0]            normal_y,
    input  logic signed [31:0]            normal_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic signed [31:0]            coord_u,
    output logic signed [31:0]            coord_v,
    output logic                          overflow,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rpi_pkg::THR_W-1:0]     cfg_data
);

    function automatic rpi_pkg::s32_t pick(input rpi_pkg::vec32_t v, input logic [1:0] s);
        rpi_pkg::s32_t r;
        case (s)
            2'd0:    r = v[0];
            2'd1:    r = v[1];
            default: r = v[2];
        endcase
        return r;
    endfunction

    logic                      adv;
    logic [rpi_pkg::THR_W-1:0] thr_reg;

    rpi_pkg::vec32_t org_in, dir_in, pp_in, nrm_in;
    logic [32:0]     dif;
    rpi_pkg::sat_t   sd;
    logic [31:0]     mag [3];
    logic [1:0]      k;

    rpi_pkg::ctx_t   s1_reg, s1_next, s2_reg, s3_reg, s4_reg, s4_next, s5_reg;
    rpi_pkg::ctx_t   s6_reg, s6_next, s7_reg, s7_next;
    rpi_pkg::vec32_t df_reg, df_next;
    logic signed [63:0] pn_reg [3];
    logic signed [63:0] pe_reg [3];
    logic signed [49:0] d_reg, e_reg;
    logic signed [63:0] dsum, esum;
    logic signed [49:0] ae;
    rpi_pkg::sat_t   ds_s, es_s;
    rpi_pkg::s32_t   ds4_reg, es4_reg, es5_reg;
    logic signed [63:0] rq_reg [3];
    logic [63:0]     nm_reg [3], nm_next [3];
    logic [31:0]     den_reg;
    logic [63:0]     dq [3];
    rpi_pkg::ctx_t   dv_pipe [rpi_pkg::DIV_LAT];
    logic signed [65:0] qs, psum;
    rpi_pkg::sat_t   ps;

    rpi_pkg::uvec_t  u0_in, w_reg, w_next, w2_reg, w2_next;
    rpi_pkg::vec32_t b0, b1, b2;
    rpi_pkg::ctx_t   u0_pipe [rpi_pkg::UNIT_LAT];
    rpi_pkg::ctx_t   u1_pipe [rpi_pkg::UNIT_LAT];
    rpi_pkg::ctx_t   u2_pipe [rpi_pkg::UNIT_LAT];
    rpi_pkg::ctx_t   g1_reg, g2_reg, g2_next, g3_reg, g3_next, g4_reg, g5_reg, g6_reg;
    rpi_pkg::ctx_t   h1_reg;
    rpi_pkg::s32_t   b0a, b0b;
    logic signed [63:0] ppa_reg [3];
    logic signed [63:0] ppb_reg [3];
    logic signed [63:0] ta, tb;
    logic signed [67:0] bt_reg [3];
    logic signed [67:0] fsum;
    logic signed [39:0] f_reg;
    logic signed [71:0] fb_reg [3];
    logic signed [71:0] wt;
    logic signed [63:0] pu_reg [3];
    logic signed [63:0] pv_reg [3];
    logic signed [63:0] usum, vsum;
    rpi_pkg::sat_t   su, sv;

    logic            out_vld_reg, hit_reg, hit_next, ov_reg, ov_next;
    rpi_pkg::s32_t   cu_reg, cu_next, cv_reg, cv_next;

    // hold every stage while a result waits at the output
    assign adv       = !(out_vld_reg && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= rpi_pkg::THR_W'(1);
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // stage 1: plane point minus origin, dominant normal axis
    assign org_in = {origin_z, origin_y, origin_x};
    assign dir_in = {direction_z, direction_y, direction_x};
    assign pp_in  = {plane_point_z, plane_point_y, plane_point_x};
    assign nrm_in = {normal_z, normal_y, normal_x};

    always_comb
    begin
        s1_next     = '0;
        s1_next.vld = in_valid;
        s1_next.org = org_in;
        s1_next.dir = dir_in;
        s1_next.nrm = nrm_in;
        for (int i = 0; i < 3; i++)
        begin
            dif = {pp_in[i][31], pp_in[i]} - {org_in[i][31], org_in[i]};
            sd  = rpi_pkg::sat32($signed(dif));
            df_next[i] = sd.val;
            s1_next.ov = s1_next.ov | sd.ov;
            mag[i] = nrm_in[i][31] ? (~nrm_in[i] + 1'b1) : nrm_in[i];
        end
        if (mag[1] > mag[0])
            k = (mag[2] > mag[1]) ? 2'd2 : 2'd1;
        else
            k = (mag[2] > mag[0]) ? 2'd2 : 2'd0;
        case (k)
            2'd0:    begin s1_next.sel_a = 2'd1; s1_next.sel_b = 2'd2; end
            2'd1:    begin s1_next.sel_a = 2'd2; s1_next.sel_b = 2'd0; end
            default: begin s1_next.sel_a = 2'd0; s1_next.sel_b = 2'd1; end
        endcase
    end

    // stage 3 and 4: dot products, parallel test
    always_comb
    begin
        dsum = (pn_reg[0] >>> rpi_pkg::FRAC_BITS) + (pn_reg[1] >>> rpi_pkg::FRAC_BITS)
             + (pn_reg[2] >>> rpi_pkg::FRAC_BITS);
        esum = (pe_reg[0] >>> rpi_pkg::FRAC_BITS) + (pe_reg[1] >>> rpi_pkg::FRAC_BITS)
             + (pe_reg[2] >>> rpi_pkg::FRAC_BITS);
        ae   = e_reg[49] ? -e_reg : e_reg;
        ds_s = rpi_pkg::sat32(d_reg);
        es_s = rpi_pkg::sat32(e_reg);
        s4_next     = s3_reg;
        s4_next.hit = (e_reg != '0) && ($unsigned(ae) >= 50'(thr_reg));
        s4_next.ov  = s3_reg.ov | ds_s.ov | es_s.ov;
    end

    // stage 6: sign and magnitude for the hit-point division
    always_comb
    begin
        s6_next = s5_reg;
        for (int i = 0; i < 3; i++)
        begin
            nm_next[i] = rq_reg[i][63] ? 64'(-rq_reg[i]) : 64'(rq_reg[i]);
            s6_next.qneg[i] = rq_reg[i][63] ^ es5_reg[31];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            df_reg <= df_next;
            for (int i = 0; i < 3; i++)
            begin
                pn_reg[i] <= $signed(s1_reg.nrm[i]) * $signed(df_reg[i]);
                pe_reg[i] <= $signed(s1_reg.nrm[i]) * $signed(s1_reg.dir[i]);
                rq_reg[i] <= $signed(s4_reg.dir[i]) * ds4_reg;
            end
            d_reg   <= dsum[49:0];
            e_reg   <= esum[49:0];
            ds4_reg <= ds_s.val;
            es4_reg <= es_s.val;
            es5_reg <= es4_reg;
            nm_reg  <= nm_next;
            den_reg <= es5_reg[31] ? 32'(-es5_reg) : 32'(es5_reg);
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_hdiv
        rpi_div u_div (
            .clk (clk),
            .en  (adv),
            .num (nm_reg[i]),
            .den (den_reg),
            .quo (dq[i])
        );
    end

    // stage 7: hit point with saturation
    always_comb
    begin
        s7_next = dv_pipe[rpi_pkg::DIV_LAT-1];
        for (int i = 0; i < 3; i++)
        begin
            qs = $signed({2'b00, dq[i]});
            if (s7_next.qneg[i])
                qs = -qs;
            psum = 66'($signed(s7_next.org[i])) + qs;
            ps   = rpi_pkg::sat32(psum);
            s7_next.pt[i] = ps.val;
            s7_next.ov = s7_next.ov | ps.ov;
        end
    end

    // first basis vector
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            u0_in[i] = rpi_pkg::UV_W'($signed(s7_reg.nrm[i]));
    end

    rpi_unit u_unit0 (
        .clk     (clk),
        .en      (adv),
        .vec_in  (u0_in),
        .vec_out (b0)
    );

    assign b0a = pick(b0, u0_pipe[rpi_pkg::UNIT_LAT-1].sel_a);
    assign b0b = pick(b0, u0_pipe[rpi_pkg::UNIT_LAT-1].sel_b);

    // remove the normal component from both unit axes
    always_comb
    begin
        g2_next = g1_reg;
        for (int i = 0; i < 3; i++)
        begin
            ta = ((g1_reg.sel_a == 2'(i)) ? rpi_pkg::UNIT_ONE : 64'sd0)
               - (ppa_reg[i] >>> rpi_pkg::UNIT_SHIFT);
            tb = ((g1_reg.sel_b == 2'(i)) ? rpi_pkg::UNIT_ONE : 64'sd0)
               - (ppb_reg[i] >>> rpi_pkg::UNIT_SHIFT);
            w_next[i]     = ta[rpi_pkg::UV_W-1:0];
            g2_next.tv[i] = tb[rpi_pkg::UV_W-1:0];
        end
    end

    rpi_unit u_unit1 (
        .clk     (clk),
        .en      (adv),
        .vec_in  (w_reg),
        .vec_out (b1)
    );

    always_comb
    begin
        g3_next    = u1_pipe[rpi_pkg::UNIT_LAT-1];
        g3_next.b1 = b1;
        fsum = (bt_reg[0] >>> rpi_pkg::UNIT_SHIFT) + (bt_reg[1] >>> rpi_pkg::UNIT_SHIFT)
             + (bt_reg[2] >>> rpi_pkg::UNIT_SHIFT);
        for (int i = 0; i < 3; i++)
        begin
            wt = 72'($signed(g5_reg.tv[i])) - (fb_reg[i] >>> rpi_pkg::UNIT_SHIFT);
            w2_next[i] = wt[rpi_pkg::UV_W-1:0];
        end
    end

    rpi_unit u_unit2 (
        .clk     (clk),
        .en      (adv),
        .vec_in  (w2_reg),
        .vec_out (b2)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ppa_reg[i] <= b0a * $signed(b0[i]);
                ppb_reg[i] <= b0b * $signed(b0[i]);
                bt_reg[i]  <= $signed(b1[i]) * $signed(u1_pipe[rpi_pkg::UNIT_LAT-1].tv[i]);
                fb_reg[i]  <= f_reg * $signed(g4_reg.b1[i]);
                pu_reg[i]  <= $signed(u2_pipe[rpi_pkg::UNIT_LAT-1].pt[i])
                            * $signed(u2_pipe[rpi_pkg::UNIT_LAT-1].b1[i]);
                pv_reg[i]  <= $signed(u2_pipe[rpi_pkg::UNIT_LAT-1].pt[i]) * $signed(b2[i]);
            end
            w_reg  <= w_next;
            f_reg  <= fsum[39:0];
            w2_reg <= w2_next;
        end
    end

    // output stage: tangent coordinates, zeroed when there is no hit
    always_comb
    begin
        usum = (pu_reg[0] >>> rpi_pkg::UNIT_SHIFT) + (pu_reg[1] >>> rpi_pkg::UNIT_SHIFT)
             + (pu_reg[2] >>> rpi_pkg::UNIT_SHIFT);
        vsum = (pv_reg[0] >>> rpi_pkg::UNIT_SHIFT) + (pv_reg[1] >>> rpi_pkg::UNIT_SHIFT)
             + (pv_reg[2] >>> rpi_pkg::UNIT_SHIFT);
        su = rpi_pkg::sat32(usum);
        sv = rpi_pkg::sat32(vsum);
        hit_next = h1_reg.hit;
        cu_next  = h1_reg.hit ? su.val : '0;
        cv_next  = h1_reg.hit ? sv.val : '0;
        ov_next  = h1_reg.hit & (h1_reg.ov | su.ov | sv.ov);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_next;
            cu_reg  <= cu_next;
            cv_reg  <= cv_next;
            ov_reg  <= ov_next;
        end
    end

    // transaction context and valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
            s6_reg <= '0;
            s7_reg <= '0;
            g1_reg <= '0;
            g2_reg <= '0;
            g3_reg <= '0;
            g4_reg <= '0;
            g5_reg <= '0;
            g6_reg <= '0;
            h1_reg <= '0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < rpi_pkg::DIV_LAT; i++)
                dv_pipe[i] <= '0;
            for (int i = 0; i < rpi_pkg::UNIT_LAT; i++)
            begin
                u0_pipe[i] <= '0;
                u1_pipe[i] <= '0;
                u2_pipe[i] <= '0;
            end
        end
        else if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s4_next;
            s5_reg <= s4_reg;
            s6_reg <= s6_next;
            dv_pipe[0] <= s6_reg;
            for (int i = 1; i < rpi_pkg::DIV_LAT; i++)
                dv_pipe[i] <= dv_pipe[i-1];
            s7_reg <= s7_next;
            u0_pipe[0] <= s7_reg;
            u1_pipe[0] <= g2_reg;
            u2_pipe[0] <= g6_reg;
            for (int i = 1; i < rpi_pkg::UNIT_LAT; i++)
            begin
                u0_pipe[i] <= u0_pipe[i-1];
                u1_pipe[i] <= u1_pipe[i-1];
                u2_pipe[i] <= u2_pipe[i-1];
            end
            g1_reg <= u0_pipe[rpi_pkg::UNIT_LAT-1];
            g2_reg <= g2_next;
            g3_reg <= g3_next;
            g4_reg <= g3_reg;
            g5_reg <= g4_reg;
            g6_reg <= g5_reg;
            h1_reg <= u2_pipe[rpi_pkg::UNIT_LAT-1];
            out_vld_reg <= h1_reg.vld;
        end
    end

    assign out_valid = out_vld_reg;
    assign hit       = hit_reg;
    assign coord_u   = cu_reg;
    assign coord_v   = cv_reg;
    assign overflow  = ov_reg;

endmodule

@@ rtl/core/rpi_check.sv @@
// Port-level checker for the ray/plane intersection block, bound to the top level.
module rpi_check (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic [31:0] coord_u,
    input logic [31:0] coord_v,
    input logic        overflow
);

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> coord_u == '0 && coord_v == '0 && !overflow)
        else $error("miss transaction carries nonzero payload");

    a_ovf_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> hit)
        else $error("overflow flagged without a hit");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(coord_u) && $stable(coord_v) && $stable(hit))
        else $error("stalled output payload changed");

endmodule

bind ray_plane_intersect_uv rpi_check u_rpi_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .coord_u   (coord_u),
    .coord_v   (coord_v),
    .overflow  (overflow)
);
